// File: sv/q2yaw_pkg.sv
// ============================================================================
// q2yaw_pkg
// Shared types, constants and helper functions for the quaternion yaw block.
// ============================================================================
package q2yaw_pkg;

    localparam int TAG_W     = 2;
    localparam int HEADING_W = 15;

    // Bit position at which the larger CORDIC operand has its top set bit.
    localparam int NORM_BIT  = 28;
    // Widths of the CORDIC vector and angle accumulators.
    localparam int CX_W      = 32;
    localparam int ANG_W     = 32;

    // Angles are held in units of 2^-22 degree.
    localparam longint ANG_ONE_DEG        = 64'd4194304;
    localparam longint DEG_PER_RAD_SCALED = 64'd240315917;

    localparam logic [ANG_W-1:0] ANG_90   = ANG_W'(90 * ANG_ONE_DEG);
    localparam logic [ANG_W-1:0] ANG_180  = ANG_W'(180 * ANG_ONE_DEG);
    localparam logic [ANG_W-1:0] ANG_360  = ANG_W'(360 * ANG_ONE_DEG);

    // Rounding to 1/64 degree drops 16 bits of the angle, half up.
    localparam int               RND_SHIFT = 16;
    localparam logic [ANG_W-1:0] RND_HALF  = ANG_W'(32768);
    localparam logic [ANG_W-RND_SHIFT-1:0] FULL_CIRCLE = (ANG_W - RND_SHIFT)'(23040);

    localparam int ATAN_TAB_N = 11;
    localparam logic [31:0] ATAN_TAB [ATAN_TAB_N] = '{
        32'd188743680, 32'd111421900, 32'd58872272, 32'd29884485, 32'd15000234,
        32'd7507429,   32'd3754631,   32'd1877430,  32'd938729,   32'd469366,
        32'd234683
    };

    // Quadrant of the result, coded as {sine negative, cosine negative}.
    typedef enum logic [1:0] {
        QD_I   = 2'b00,
        QD_II  = 2'b01,
        QD_IV  = 2'b10,
        QD_III = 2'b11
    } t_quad;

    // Flags that travel beside the datapath through every stage.
    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic             num_neg;
        logic             den_neg;
        logic             zero;
    } t_side;

    // Rotation angle atan(2^-i) of CORDIC step i, in units of 2^-22 degree.
    function automatic logic [ANG_W-1:0] atan_step(input int i);
        logic [63:0] t;
        logic [3:0]  idx;
        begin
            idx = i[3:0];
            t   = (64'(DEG_PER_RAD_SCALED) + (64'd1 << (i - 1))) >> i;
            if (i < ATAN_TAB_N) begin
                return ANG_W'(ATAN_TAB[idx]);
            end
            return t[ANG_W-1:0];
        end
    endfunction

    // Position of the highest set bit within one byte.
    function automatic logic [2:0] lead8(input logic [7:0] v);
        logic [2:0] p;
        begin
            p = 3'd0;
            for (int b = 0; b < 8; b++) begin
                if (v[b]) begin
                    p = 3'(b);
                end
            end
            return p;
        end
    endfunction

endpackage

// File: sv/q2yaw_quat_if.sv
// ============================================================================
// q2yaw_quat_if
// Input channel: one orientation quaternion and its stream tag per word.
// ============================================================================
interface q2yaw_quat_if #(
    parameter int COMPONENT_WIDTH = 16
);
    logic                              valid;
    logic                              ready;
    logic signed [COMPONENT_WIDTH-1:0] quat_w;
    logic signed [COMPONENT_WIDTH-1:0] quat_x;
    logic signed [COMPONENT_WIDTH-1:0] quat_y;
    logic signed [COMPONENT_WIDTH-1:0] quat_z;
    logic [q2yaw_pkg::TAG_W-1:0]       stream_tag;

    modport source (
        output valid, quat_w, quat_x, quat_y, quat_z, stream_tag,
        input  ready
    );
    modport sink (
        input  valid, quat_w, quat_x, quat_y, quat_z, stream_tag,
        output ready
    );
endinterface

// File: sv/q2yaw_yaw_if.sv
// ============================================================================
// q2yaw_yaw_if
// Output channel: one heading in 1/64 degree and its tag per word.
// ============================================================================
interface q2yaw_yaw_if;
    logic                            valid;
    logic                            ready;
    logic [q2yaw_pkg::HEADING_W-1:0] heading;
    logic [q2yaw_pkg::TAG_W-1:0]     heading_tag;

    modport source (
        output valid, heading, heading_tag,
        input  ready
    );
    modport sink (
        input  valid, heading, heading_tag,
        output ready
    );
endinterface

// File: sv/quaternion_to_yaw_degrees.sv
// ============================================================================
// quaternion_to_yaw_degrees
// Yaw heading from an orientation quaternion, via a pipelined CORDIC atan2.
// ============================================================================
// The block takes one quaternion word per clock while its output is taken and
// returns its yaw heading, in 1/64 degree from 0 to 23039, with the stream tag
// copied through. Every input word gives exactly one output word, in order:
// three stages form the sine and cosine terms and their magnitudes, two find
// the leading one and one normalizes, the CORDIC takes one stage per rotation,
// and three clamp, map the quadrant and round. The whole pipeline advances
// together; it holds only while the output word is not taken, so the rate is
// one word per cycle only while each output word is taken.
module quaternion_to_yaw_degrees #(
    parameter int CORDIC_STAGES   = 16,
    parameter int COMPONENT_WIDTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    q2yaw_quat_if.sink  i_quat,
    q2yaw_yaw_if.source o_yaw
);
    import q2yaw_pkg::*;

    localparam int W   = COMPONENT_WIDTH;
    localparam int MW  = 2 * W;            // product and magnitude width
    localparam int SW  = 2 * W + 1;        // signed sum width
    localparam int NCH = (MW + 7) / 8;     // byte chunks for leading-one search
    localparam int PADW = NCH * 8;
    localparam int PW  = $clog2(NCH) + 3;
    localparam int XW  = MW + NORM_BIT;
    localparam int N   = CORDIC_STAGES;
    localparam int NST = N + 9;

    localparam int ST_MAG   = 2;
    localparam int ST_PICK  = 4;
    localparam int ST_CLAMP = N + 6;

    localparam logic signed [SW-1:0] HALF = SW'(1) <<< (2 * W - 5);

    logic en;
    logic [NST-1:0] r_vld;
    t_side r_side [NST];
    t_side n_side [NST];

    // Stage 0: products.
    logic signed [MW-1:0] r_wz, r_xy, r_yy, r_zz;
    // Stage 1: sine and cosine terms.
    logic signed [SW-1:0] r_num, r_den, n_num, n_den;
    // Stage 2: magnitudes.
    logic [MW-1:0] r_nm2, r_dm2, n_nm2, n_dm2;
    // Stage 3: per-byte leading-one detection.
    logic [PADW-1:0] big_pad;
    logic [NCH-1:0]  r_nz, n_nz;
    logic [2:0]      r_lpos [NCH];
    logic [2:0]      n_lpos [NCH];
    logic [MW-1:0]   r_nm3, r_dm3;
    // Stage 4: leading-one position.
    logic [PW-1:0]   r_pos, n_pos;
    logic [MW-1:0]   r_nm4, r_dm4;
    // Stage 5 and CORDIC stages.
    logic [XW-1:0]   sh_nm, sh_dm;
    logic signed [CX_W-1:0]  r_cx  [N+1];
    logic signed [CX_W-1:0]  r_cy  [N+1];
    logic signed [ANG_W-1:0] r_ang [N+1];
    logic signed [CX_W-1:0]  n_cx  [N+1];
    logic signed [CX_W-1:0]  n_cy  [N+1];
    logic signed [ANG_W-1:0] n_ang [N+1];
    // Final stages.
    logic [ANG_W-1:0] r_angc, n_angc;
    logic [ANG_W-1:0] r_tr, n_tr;
    logic [ANG_W-RND_SHIFT-1:0] head_raw;
    logic [HEADING_W-1:0] r_head, n_head;

    // The pipeline moves as one; it holds only while the last word waits.
    assign en           = ~r_vld[NST-1] | o_yaw.ready;
    assign i_quat.ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NST-2:0], i_quat.valid};
        end
    end

    always_comb begin
        for (int k = 0; k < NST; k++) begin
            n_side[k] = (k == 0) ? r_side[0] : r_side[k-1];
        end
        n_side[0].tag     = i_quat.stream_tag;
        n_side[0].num_neg = 1'b0;
        n_side[0].den_neg = 1'b0;
        n_side[0].zero    = 1'b0;
        n_side[ST_MAG].num_neg = r_num[SW-1];
        n_side[ST_MAG].den_neg = r_den[SW-1];
        n_side[ST_PICK].zero   = ~|r_nz;
    end

    always_comb begin
        n_num = $signed({r_wz[MW-1], r_wz}) + $signed({r_xy[MW-1], r_xy});
        n_den = HALF - $signed({r_yy[MW-1], r_yy}) - $signed({r_zz[MW-1], r_zz});
    end

    always_comb begin
        n_nm2 = r_num[SW-1] ? MW'(-r_num) : MW'(r_num);
        n_dm2 = r_den[SW-1] ? MW'(-r_den) : MW'(r_den);
    end

    // The leading one of the larger magnitude is the leading one of their OR.
    always_comb begin
        big_pad = PADW'(r_nm2 | r_dm2);
        for (int c = 0; c < NCH; c++) begin
            n_nz[c]   = |big_pad[c*8 +: 8];
            n_lpos[c] = lead8(big_pad[c*8 +: 8]);
        end
    end

    always_comb begin
        n_pos = '0;
        for (int c = 0; c < NCH; c++) begin
            if (r_nz[c]) begin
                n_pos = PW'(c * 8) + PW'(r_lpos[c]);
            end
        end
    end

    // Placing NORM_BIT zeros below the value and shifting right by the
    // leading-one position puts that bit exactly at NORM_BIT.
    always_comb begin
        sh_nm  = {r_nm4, {NORM_BIT{1'b0}}} >> r_pos;
        sh_dm  = {r_dm4, {NORM_BIT{1'b0}}} >> r_pos;
        n_cx[0]  = $signed(CX_W'(sh_dm[NORM_BIT:0]));
        n_cy[0]  = $signed(CX_W'(sh_nm[NORM_BIT:0]));
        n_ang[0] = '0;
    end

    for (genvar i = 0; i < N; i++) begin : g_cordic
        localparam logic signed [ANG_W-1:0] STEP = atan_step(i);
        always_comb begin
            if (!r_cy[i][CX_W-1]) begin
                n_cx[i+1]  = r_cx[i] + (r_cy[i] >>> i);
                n_cy[i+1]  = r_cy[i] - (r_cx[i] >>> i);
                n_ang[i+1] = r_ang[i] + STEP;
            end else begin
                n_cx[i+1]  = r_cx[i] - (r_cy[i] >>> i);
                n_cy[i+1]  = r_cy[i] + (r_cx[i] >>> i);
                n_ang[i+1] = r_ang[i] - STEP;
            end
        end
    end

    always_comb begin
        if (r_ang[N][ANG_W-1]) begin
            n_angc = '0;
        end else if ($unsigned(r_ang[N]) > ANG_90) begin
            n_angc = ANG_90;
        end else begin
            n_angc = $unsigned(r_ang[N]);
        end
    end

    always_comb begin
        unique case (t_quad'({r_side[ST_CLAMP].num_neg, r_side[ST_CLAMP].den_neg}))
            QD_I:    n_tr = r_angc + RND_HALF;
            QD_II:   n_tr = (ANG_180 + RND_HALF) - r_angc;
            QD_III:  n_tr = (ANG_180 + RND_HALF) + r_angc;
            QD_IV:   n_tr = (ANG_360 + RND_HALF) - r_angc;
            default: n_tr = r_angc + RND_HALF;
        endcase
    end

    always_comb begin
        head_raw = r_tr[ANG_W-1:RND_SHIFT];
        if (r_side[NST-2].zero) begin
            n_head = '0;
        end else if (head_raw >= FULL_CIRCLE) begin
            n_head = HEADING_W'(head_raw - FULL_CIRCLE);
        end else begin
            n_head = HEADING_W'(head_raw);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < NST; k++) begin
                r_side[k] <= n_side[k];
            end
            r_wz   <= i_quat.quat_w * i_quat.quat_z;
            r_xy   <= i_quat.quat_x * i_quat.quat_y;
            r_yy   <= i_quat.quat_y * i_quat.quat_y;
            r_zz   <= i_quat.quat_z * i_quat.quat_z;
            r_num  <= n_num;
            r_den  <= n_den;
            r_nm2  <= n_nm2;
            r_dm2  <= n_dm2;
            r_nz   <= n_nz;
            r_lpos <= n_lpos;
            r_nm3  <= r_nm2;
            r_dm3  <= r_dm2;
            r_pos  <= n_pos;
            r_nm4  <= r_nm3;
            r_dm4  <= r_dm3;
            for (int k = 0; k <= N; k++) begin
                r_cx[k]  <= n_cx[k];
                r_cy[k]  <= n_cy[k];
                r_ang[k] <= n_ang[k];
            end
            r_angc <= n_angc;
            r_tr   <= n_tr;
            r_head <= n_head;
        end
    end

    assign o_yaw.valid       = r_vld[NST-1];
    assign o_yaw.heading     = r_head;
    assign o_yaw.heading_tag = r_side[NST-1].tag;

    // A valid heading never reaches a full circle.
    a_heading_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_yaw.valid |-> (o_yaw.heading < HEADING_W'(23040)))
        else $error("heading out of range");

    // Input is refused only while a finished word waits at the output.
    a_ready_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_quat.ready |-> (o_yaw.valid && !o_yaw.ready))
        else $error("input stalled without output back-pressure");

    // Every advance moves the valid bit of the next-to-last stage into the last stage.
    a_valid_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        en |=> (r_vld[NST-1] == $past(r_vld[NST-2])))
        else $error("valid bit lost or repeated in the pipeline");

    // The clamped quadrant angle stays within a quarter turn.
    a_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[ST_CLAMP] |-> (r_angc <= ANG_90))
        else $error("quadrant angle above 90 degrees");

endmodule

// File: bench/quaternion_to_yaw_degrees_test.sv
// ============================================================================
// quaternion_to_yaw_degrees_test
// Self-checking bench for the quaternion to yaw heading block.
// ============================================================================
// Poses are queued by the stimulus process. A falling-edge driver offers them
// on the input channel, and a rising-edge monitor checks every heading word
// against a bit-exact model of the normalize, CORDIC and rounding datapath.
// The run uses three idle profiles, one long output stall that backs up the
// pipeline, and a full drain between profiles.
// ============================================================================
module quaternion_to_yaw_degrees_test;
    timeunit 1ns;
    timeprecision 1ps;

    import q2yaw_pkg::*;

    localparam int STAGES     = 16;
    localparam int COMP_W     = 16;
    localparam int LATENCY    = STAGES + 9;
    localparam int DRAIN_WAIT = 2 * LATENCY;
    localparam int STALL_MAX  = 3000;
    localparam int HOLD_AT    = 150;
    localparam int HOLD_LEN   = 300;

    localparam longint DEG_UNIT  = 64'sd4194304;
    localparam longint HALF_TERM = 64'sd1 <<< 27;
    localparam longint NORM_TOP  = 64'sd1 <<< 29;
    localparam longint NORM_BOT  = 64'sd1 <<< 28;
    localparam longint RAD_DEG   = 64'sd240315917;
    localparam longint ROT_TAB [11] = '{
        64'sd188743680, 64'sd111421900, 64'sd58872272, 64'sd29884485,
        64'sd15000234,  64'sd7507429,   64'sd3754631,  64'sd1877430,
        64'sd938729,    64'sd469366,    64'sd234683
    };
    localparam logic signed [COMP_W-1:0] CORNERS [7] = '{
        16'sh8000, -16'sd16384, -16'sd1, 16'sd0, 16'sd1, 16'sd16384, 16'sd32767
    };
    localparam real PI = 3.14159265358979;

    typedef struct packed {
        logic signed [COMP_W-1:0] w;
        logic signed [COMP_W-1:0] x;
        logic signed [COMP_W-1:0] y;
        logic signed [COMP_W-1:0] z;
        logic [TAG_W-1:0]         tag;
    } t_pose;

    typedef struct packed {
        logic [HEADING_W-1:0] heading;
        logic [TAG_W-1:0]     tag;
    } t_yaw;

    logic i_clk;
    logic i_rst_n;

    q2yaw_quat_if #(.COMPONENT_WIDTH(COMP_W)) quat_ch ();
    q2yaw_yaw_if yaw_ch ();

    quaternion_to_yaw_degrees #(
        .CORDIC_STAGES  (STAGES),
        .COMPONENT_WIDTH(COMP_W)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_quat (quat_ch.sink),
        .o_yaw  (yaw_ch.source)
    );

    t_pose pose_q[$];
    t_yaw  heading_q[$];

    int   src_idle_pct;
    int   snk_idle_pct;
    int   poses_sent;
    int   headings_checked;
    int   errors;
    int   stall_cycles;
    int   hold_left;
    bit   hold_done;
    bit   pose_taken;
    t_yaw want;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Rotation angle of CORDIC step i in units of 2^-22 degree.
    function automatic longint rot_angle(input int i);
        if (i < 11) begin
            return ROT_TAB[i];
        end
        return (RAD_DEG + (64'sd1 <<< (i - 1))) >>> i;
    endfunction

    function automatic t_yaw predict_heading(input t_pose p);
        longint w, x, y, z;
        longint num, den, nm, dm, big;
        longint cx, cy, sx, sy, ang, theta, hd;
        t_quad  quad;
        t_yaw   r;
        w   = longint'(p.w);
        x   = longint'(p.x);
        y   = longint'(p.y);
        z   = longint'(p.z);
        num = w * z + x * y;
        den = HALF_TERM - (y * y + z * z);
        nm  = (num < 0) ? -num : num;
        dm  = (den < 0) ? -den : den;
        r.tag = p.tag;
        if (nm == 0 && dm == 0) begin
            r.heading = '0;
            return r;
        end
        big = (nm > dm) ? nm : dm;
        while (big >= NORM_TOP) begin
            big = big >>> 1;
            nm  = nm >>> 1;
            dm  = dm >>> 1;
        end
        while (big < NORM_BOT) begin
            big = big <<< 1;
            nm  = nm <<< 1;
            dm  = dm <<< 1;
        end
        cx  = dm;
        cy  = nm;
        ang = 0;
        for (int i = 0; i < STAGES; i++) begin
            // Arithmetic shifts of signed values round toward minus infinity.
            sx = cx >>> i;
            sy = cy >>> i;
            if (cy >= 0) begin
                cx  = cx + sy;
                cy  = cy - sx;
                ang = ang + rot_angle(i);
            end else begin
                cx  = cx - sy;
                cy  = cy + sx;
                ang = ang - rot_angle(i);
            end
        end
        if (ang < 0) begin
            ang = 0;
        end
        if (ang > 90 * DEG_UNIT) begin
            ang = 90 * DEG_UNIT;
        end
        quad = t_quad'({num < 0, den < 0});
        case (quad)
            QD_I:    theta = ang;
            QD_II:   theta = 180 * DEG_UNIT - ang;
            QD_III:  theta = 180 * DEG_UNIT + ang;
            default: theta = 360 * DEG_UNIT - ang;
        endcase
        hd = (theta + 64'sd32768) >>> 16;
        if (hd >= 23040) begin
            hd = hd - 23040;
        end
        r.heading = hd[HEADING_W-1:0];
        return r;
    endfunction

    // Input side: a word moves when valid and ready are both high at the edge.
    always @(posedge i_clk) begin
        pose_taken = i_rst_n && quat_ch.valid && quat_ch.ready;
        if (pose_taken) begin
            heading_q.push_back(predict_heading({quat_ch.quat_w, quat_ch.quat_x,
                quat_ch.quat_y, quat_ch.quat_z, quat_ch.stream_tag}));
            pose_q.pop_front();
            poses_sent++;
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            quat_ch.valid <= 1'b0;
        end else if (!quat_ch.valid || pose_taken) begin
            if (pose_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                quat_ch.valid      <= 1'b1;
                quat_ch.quat_w     <= pose_q[0].w;
                quat_ch.quat_x     <= pose_q[0].x;
                quat_ch.quat_y     <= pose_q[0].y;
                quat_ch.quat_z     <= pose_q[0].z;
                quat_ch.stream_tag <= pose_q[0].tag;
            end else begin
                // Idle cycles carry junk so that the block must honor valid.
                quat_ch.valid      <= 1'b0;
                quat_ch.quat_w     <= COMP_W'($urandom);
                quat_ch.quat_x     <= COMP_W'($urandom);
                quat_ch.quat_y     <= COMP_W'($urandom);
                quat_ch.quat_z     <= COMP_W'($urandom);
                quat_ch.stream_tag <= TAG_W'($urandom);
            end
        end
    end

    // Output ready, with one long hold-off once enough poses have gone in.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            yaw_ch.ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left--;
            yaw_ch.ready <= 1'b0;
        end else if (!hold_done && poses_sent >= HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_LEN;
            yaw_ch.ready <= 1'b0;
        end else begin
            yaw_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && yaw_ch.valid && yaw_ch.ready) begin
            if (heading_q.size() == 0) begin
                $error("heading word %0d with no pose outstanding", yaw_ch.heading);
                errors++;
            end else begin
                want = heading_q.pop_front();
                if (yaw_ch.heading !== want.heading) begin
                    $error("heading: expected %0d, actual %0d", want.heading,
                           yaw_ch.heading);
                    errors++;
                end
                if (yaw_ch.heading_tag !== want.tag) begin
                    $error("heading_tag: expected %0d, actual %0d", want.tag,
                           yaw_ch.heading_tag);
                    errors++;
                end
                headings_checked++;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((quat_ch.valid && quat_ch.ready) || (yaw_ch.valid && yaw_ch.ready)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
            end
            if (stall_cycles >= STALL_MAX) begin
                $display("Timeout: no word moved for %0d cycles", STALL_MAX);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    task automatic offer(input int w, input int x, input int y, input int z,
                         input int tag);
        t_pose p;
        p.w   = COMP_W'(w);
        p.x   = COMP_W'(x);
        p.y   = COMP_W'(y);
        p.z   = COMP_W'(z);
        p.tag = TAG_W'(tag);
        pose_q.push_back(p);
    endtask

    task automatic add_random(input int count);
        t_pose p;
        real   half_ang;
        int    pick;
        for (int n = 0; n < count; n++) begin
            pick  = $urandom_range(9);
            p.tag = TAG_W'($urandom);
            if (pick <= 3) begin
                // Unit yaw rotation with a little roll and pitch mixed in.
                half_ang = real'($urandom_range(35999)) * PI / 36000.0;
                p.w = COMP_W'($rtoi($cos(half_ang) * 16384.0));
                p.z = COMP_W'($rtoi($sin(half_ang) * 16384.0));
                p.x = COMP_W'(int'($urandom_range(3000)) - 1500);
                p.y = COMP_W'(int'($urandom_range(3000)) - 1500);
            end else if (pick <= 6) begin
                p.w = COMP_W'($urandom);
                p.x = COMP_W'($urandom);
                p.y = COMP_W'($urandom);
                p.z = COMP_W'($urandom);
            end else if (pick == 7) begin
                p.w = COMP_W'(int'($urandom_range(32768)) - 16384);
                p.x = COMP_W'(int'($urandom_range(32768)) - 16384);
                p.y = COMP_W'(int'($urandom_range(32768)) - 16384);
                p.z = COMP_W'(int'($urandom_range(32768)) - 16384);
            end else if (pick == 8) begin
                // Both terms near zero, so normalization shifts left a long way.
                p.w = COMP_W'(int'($urandom_range(8)) - 4);
                p.x = COMP_W'(int'($urandom_range(8)) - 4);
                p.y = COMP_W'(8192 + int'($urandom_range(16)) - 8);
                p.z = COMP_W'(8192 + int'($urandom_range(16)) - 8);
                if ($urandom_range(1) != 0) begin
                    p.z = -p.z;
                end
            end else begin
                p.w = CORNERS[$urandom_range(6)];
                p.x = CORNERS[$urandom_range(6)];
                p.y = CORNERS[$urandom_range(6)];
                p.z = CORNERS[$urandom_range(6)];
            end
            pose_q.push_back(p);
        end
    endtask

    // Sender holds back until every heading already owed has come out.
    task automatic wait_drained();
        while (pose_q.size() != 0 || heading_q.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    initial begin
        i_rst_n            = 1'b0;
        quat_ch.valid      = 1'b0;
        quat_ch.quat_w     = '0;
        quat_ch.quat_x     = '0;
        quat_ch.quat_y     = '0;
        quat_ch.quat_z     = '0;
        quat_ch.stream_tag = '0;
        yaw_ch.ready       = 1'b0;
        src_idle_pct       = 14;
        snk_idle_pct       = 52;
        poses_sent         = 0;
        headings_checked   = 0;
        errors             = 0;
        stall_cycles       = 0;
        hold_left          = 0;
        hold_done          = 1'b0;
        pose_taken         = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(posedge i_clk);

        offer(16384, 0, 0, 0, 0);
        offer(11585, 0, 0, 11585, 1);
        offer(0, 0, 0, 16384, 2);
        offer(11585, 0, 0, -11585, 3);
        offer(-11585, 0, 0, 11585, 0);
        offer(0, 0, 0, 0, 1);
        // Sine and cosine terms both exactly zero.
        offer(0, 0, 8192, 8192, 2);
        offer(0, 0, -8192, 8192, 3);
        // Tiny negative yaw rounds up to a full circle and wraps to zero.
        offer(16384, 0, 0, -1, 0);
        offer(16384, 0, 0, 1, 1);
        offer(1, 0, 0, 16384, 2);
        offer(-1, 0, 0, 16384, 3);
        offer(0, 16384, 0, 0, 0);
        // Zero sine with a negative cosine gives a half turn.
        offer(0, 0, 16384, 0, 1);
        offer(0, 11585, 11585, 0, 2);
        offer(-32768, -32768, -32768, -32768, 3);
        offer(32767, 32767, 32767, 32767, 0);
        offer(32767, -32768, 32767, -32768, 1);
        offer(-32768, 32767, -32768, 32767, 2);
        offer(-16384, 16384, -16384, 16384, 3);
        offer(16384, 16384, 16384, 16384, 0);
        add_random(280);
        wait_drained();

        src_idle_pct = 52;
        snk_idle_pct = 14;
        add_random(285);
        wait_drained();

        src_idle_pct = 0;
        snk_idle_pct = 0;
        add_random(285);
        wait_drained();

        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (heading_q.size() != 0) begin
            $error("%0d headings never arrived", heading_q.size());
            errors++;
        end
        $display("Summary: %0d poses in, %0d headings checked, %0d mismatches.",
                 poses_sent, headings_checked, errors);
        $display("Covered edge poses, three idle profiles, a long output stall and drains.");
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// File: files.f
sv/q2yaw_pkg.sv
sv/q2yaw_quat_if.sv
sv/q2yaw_yaw_if.sv
sv/quaternion_to_yaw_degrees.sv
bench/quaternion_to_yaw_degrees_test.sv
